// ===== rtl/string_key_hash_table_core_macros.svh =====
// Assertion macros shared by the string key hash table RTL.
`ifndef STRING_KEY_HASH_TABLE_CORE_MACROS_SVH
`define STRING_KEY_HASH_TABLE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SKHT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("skht assertion failed");
`define SKHT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("skht assertion failed");
`else
`define SKHT_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SKHT_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/skht_pkg.sv =====
// Types and constants shared by the string key hash table modules.
package skht_pkg;
   localparam int CHAR_W     = 7;
   localparam int VALUE_W    = 31;
   localparam int COUNT_W    = 11;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 48;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_FOUND     = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_EMPTY     = 3'd3,
      ST_FULL      = 3'd4,
      ST_TOO_LONG  = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      OP_INSERT    = 2'd0,
      OP_LOOKUP    = 2'd1,
      OP_IMMEDIATE = 2'd2
   } op_type;

   typedef struct packed {
      op_type     op;
      status_type imm_status;
   } cmd_ctrl_type;
endpackage

// ===== rtl/skht_cmd_fifo.sv =====
// Two-entry command queue between the front and back parts.
module skht_cmd_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

// ===== rtl/skht_front.sv =====
// Front part: collects key characters, folds the hash and queues one command per key.
`include "string_key_hash_table_core_macros.svh"
module skht_front #(
   parameter int TABLE_DEPTH = 1024,
   parameter int KEY_LEN     = 20
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    hold,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic                                    req_func,
   input  logic [skht_pkg::CHAR_W-1:0]             req_key_char,
   input  logic                                    req_last,
   input  logic [skht_pkg::VALUE_W-1:0]            req_value,
   output logic                                    cmd_push,
   input  logic                                    cmd_full,
   output skht_pkg::cmd_ctrl_type                  cmd_ctrl,
   output logic [KEY_LEN*skht_pkg::CHAR_W-1:0]     cmd_key,
   output logic [$clog2(TABLE_DEPTH)-1:0]          cmd_home,
   output logic [skht_pkg::VALUE_W-1:0]            cmd_value
);
   import skht_pkg::*;

   localparam int HASH_W  = $clog2(TABLE_DEPTH);
   localparam int SUM_W   = $clog2(TABLE_DEPTH + 127);
   localparam int PROD_W  = SUM_W + CHAR_W;
   localparam int DEP_W   = $clog2(TABLE_DEPTH + 1);
   localparam int SHIFT   = PROD_W + HASH_W;
   localparam int RECIP_W = PROD_W + 1;
   localparam int SCALE_W = PROD_W + RECIP_W;
   localparam int QUOT_W  = PROD_W - HASH_W + 1;
   localparam int MULT_W  = QUOT_W + DEP_W;
   localparam longint unsigned RECIP =
      ((64'd1 << SHIFT) + 64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH);
   localparam int STEP_W  = 1;
   localparam int LEN_W   = $clog2(KEY_LEN + 1);
   localparam int IDX_W   = (KEY_LEN > 1) ? $clog2(KEY_LEN) : 1;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_MOD  = 4'b0010,
      S_PUSH = 4'b0100,
      S_SPARE = 4'b1000
   } state_type;

   state_type                         state_ff, state_in;
   logic [KEY_LEN-1:0][CHAR_W-1:0]    key_ff, key_in;
   logic [LEN_W-1:0]                  len_ff, len_in;
   logic [HASH_W-1:0]                 hash_ff, hash_in;
   logic                              too_long_ff, too_long_in;
   logic                              last_ff, last_in;
   logic                              func_ff, func_in;
   logic [VALUE_W-1:0]                value_ff, value_in;
   logic [PROD_W-1:0]                 rem_ff, rem_in;
   logic [STEP_W-1:0]                 step_ff, step_in;
   logic [QUOT_W-1:0]                 quot_ff, quot_in;
   logic [SUM_W-1:0]                  sum;
   logic [SCALE_W-1:0]                scaled;
   logic [MULT_W-1:0]                 multiple;
   logic [PROD_W-1:0]                 rem_next;
   logic                              accept;

   assign req_tready = (state_ff == S_IDLE) && !hold;
   assign accept     = req_tvalid && req_tready;
   assign cmd_push   = (state_ff == S_PUSH) && !cmd_full;
   assign cmd_key    = key_ff;
   assign cmd_home   = hash_ff;
   assign cmd_value  = value_ff;

   always_comb begin
      cmd_ctrl.op         = (func_ff == FUNC_LOOKUP) ? OP_LOOKUP : OP_INSERT;
      cmd_ctrl.imm_status = ST_INSERTED;
      if (too_long_ff) begin
         cmd_ctrl.op         = OP_IMMEDIATE;
         cmd_ctrl.imm_status = ST_TOO_LONG;
      end else if (len_ff == '0) begin
         cmd_ctrl.op         = OP_IMMEDIATE;
         cmd_ctrl.imm_status = (func_ff == FUNC_INSERT) ? ST_EMPTY : ST_NOT_FOUND;
      end
   end

   // The product is reduced modulo the table depth by a reciprocal multiplication:
   // the quotient is registered and the remainder is then taken from the registered quotient.
   always_comb begin
      scaled   = SCALE_W'(rem_ff) * SCALE_W'(RECIP);
      quot_in  = scaled[SHIFT +: QUOT_W];
      multiple = MULT_W'(quot_ff) * MULT_W'(TABLE_DEPTH);
      rem_next = rem_ff - multiple[PROD_W-1:0];
   end

   always_comb begin
      state_in    = state_ff;
      key_in      = key_ff;
      len_in      = len_ff;
      hash_in     = hash_ff;
      too_long_in = too_long_ff;
      last_in     = last_ff;
      func_in     = func_ff;
      value_in    = value_ff;
      rem_in      = rem_ff;
      step_in     = step_ff;
      sum         = SUM_W'(hash_ff) + SUM_W'(req_key_char);
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               last_in  = req_last;
               func_in  = req_func;
               value_in = req_value;
               state_in = req_last ? S_PUSH : S_IDLE;
               if (req_key_char != '0) begin
                  if (len_ff < LEN_W'(KEY_LEN)) begin
                     key_in[len_ff[IDX_W-1:0]] = req_key_char;
                     len_in   = len_ff + LEN_W'(1);
                     rem_in   = PROD_W'(sum) * PROD_W'(req_key_char);
                     step_in  = STEP_W'(1);
                     state_in = S_MOD;
                  end else begin
                     too_long_in = 1'b1;
                  end
               end
            end
         end
         S_MOD: begin
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               hash_in  = rem_next[HASH_W-1:0];
               state_in = last_ff ? S_PUSH : S_IDLE;
            end
         end
         S_PUSH: begin
            if (!cmd_full) begin
               key_in      = '0;
               len_in      = '0;
               hash_in     = '0;
               too_long_in = 1'b0;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         key_ff      <= '0;
         len_ff      <= '0;
         hash_ff     <= '0;
         too_long_ff <= 1'b0;
         last_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         key_ff      <= key_in;
         len_ff      <= len_in;
         hash_ff     <= hash_in;
         too_long_ff <= too_long_in;
         last_ff     <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff  <= func_in;
      value_ff <= value_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
      quot_ff  <= quot_in;
   end

   `SKHT_ASSERT_NEXT(a_key_cleared, clock, reset, cmd_push, (len_ff == '0) && (hash_ff == '0) && !too_long_ff)
   `SKHT_ASSERT_IMP(a_len_bound, clock, reset, 1'b1, len_ff <= LEN_W'(KEY_LEN))
   `SKHT_ASSERT_NEXT(a_hash_bound, clock, reset, (state_ff == S_MOD) && (step_ff == '0), DEP_W'(hash_ff) < DEP_W'(TABLE_DEPTH))
endmodule

// ===== rtl/skht_back.sv =====
// Back part: clears the slot memory, probes it linearly and registers each result.
`include "string_key_hash_table_core_macros.svh"
module skht_back #(
   parameter int TABLE_DEPTH = 1024,
   parameter int KEY_LEN     = 20
) (
   input  logic                                    clock,
   input  logic                                    reset,
   output logic                                    clearing,
   input  logic                                    cmd_empty,
   output logic                                    cmd_pop,
   input  skht_pkg::cmd_ctrl_type                  cmd_ctrl,
   input  logic [KEY_LEN*skht_pkg::CHAR_W-1:0]     cmd_key,
   input  logic [$clog2(TABLE_DEPTH)-1:0]          cmd_home,
   input  logic [skht_pkg::VALUE_W-1:0]            cmd_value,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output skht_pkg::status_type                    rsp_status,
   output logic [skht_pkg::VALUE_W-1:0]            rsp_value_res,
   output logic [skht_pkg::COUNT_W-1:0]            rsp_entry_count
);
   import skht_pkg::*;

   localparam int KEY_W  = KEY_LEN * CHAR_W;
   localparam int ROW_W  = 1 + VALUE_W + KEY_W;
   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int DEP_W  = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_READ  = 4'b0100,
      S_CHECK = 4'b1000
   } state_type;

   logic [ROW_W-1:0]      slot_mem [TABLE_DEPTH];
   logic [ROW_W-1:0]      row_ff;
   state_type             state_ff, state_in;
   logic [ADDR_W-1:0]     slot_ff, slot_in;
   logic [DEP_W-1:0]      probe_ff, probe_in;
   logic [DEP_W-1:0]      count_ff, count_in;
   op_type                op_ff, op_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [VALUE_W-1:0]    value_ff, value_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [COUNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic [DEP_W+COUNT_W-1:0] count_ext;
   logic                  mem_we;
   logic [ROW_W-1:0]      mem_wdata;
   logic                  row_used;
   logic [VALUE_W-1:0]    row_value;
   logic [KEY_W-1:0]      row_key;
   logic                  last_slot;

   assign clearing        = (state_ff == S_CLEAR);
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_value_res   = rsp_value_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign row_used        = row_ff[ROW_W-1];
   assign row_value       = row_ff[KEY_W +: VALUE_W];
   assign row_key         = row_ff[KEY_W-1:0];
   assign last_slot       = (DEP_W'(slot_ff) == DEP_W'(TABLE_DEPTH - 1));
   assign cmd_pop         = (state_ff == S_IDLE) && !cmd_empty && !rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      slot_in       = slot_ff;
      probe_in      = probe_ff;
      count_in      = count_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      mem_we        = 1'b0;
      mem_wdata     = '0;
      count_ext     = {{COUNT_W{1'b0}}, count_ff};
      unique case (state_ff)
         S_CLEAR: begin
            mem_we  = 1'b1;
            slot_in = last_slot ? '0 : slot_ff + ADDR_W'(1);
            if (last_slot) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (cmd_pop) begin
               op_in    = cmd_ctrl.op;
               key_in   = cmd_key;
               value_in = cmd_value;
               slot_in  = cmd_home;
               probe_in = '0;
               if (cmd_ctrl.op == OP_IMMEDIATE) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = cmd_ctrl.imm_status;
                  rsp_value_in  = '0;
                  rsp_count_in  = count_ext[COUNT_W-1:0];
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if ((op_ff == OP_INSERT) && !row_used) begin
               mem_we        = 1'b1;
               mem_wdata     = {1'b1, value_ff, key_ff};
               count_in      = count_ff + DEP_W'(1);
               count_ext     = {{COUNT_W{1'b0}}, count_in};
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_INSERTED;
               rsp_value_in  = '0;
               rsp_count_in  = count_ext[COUNT_W-1:0];
               state_in      = S_IDLE;
            end else if ((op_ff == OP_LOOKUP) && row_used && (row_key == key_ff)) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_FOUND;
               rsp_value_in  = row_value;
               rsp_count_in  = count_ext[COUNT_W-1:0];
               state_in      = S_IDLE;
            end else if (probe_ff == DEP_W'(TABLE_DEPTH - 1)) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = (op_ff == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
               rsp_value_in  = '0;
               rsp_count_in  = count_ext[COUNT_W-1:0];
               state_in      = S_IDLE;
            end else begin
               slot_in  = last_slot ? '0 : slot_ff + ADDR_W'(1);
               probe_in = probe_ff + DEP_W'(1);
               state_in = S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[slot_ff] <= mem_wdata;
      end
      row_ff <= slot_mem[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         slot_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      probe_ff      <= probe_in;
      op_ff         <= op_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
   end

   `SKHT_ASSERT_IMP(a_insert_free_slot, clock, reset, mem_we && (state_ff == S_CHECK), !row_used)
   `SKHT_ASSERT_IMP(a_pop_when_free, clock, reset, cmd_pop, !rsp_valid_ff && !clearing)
   `SKHT_ASSERT_IMP(a_probe_bound, clock, reset, state_ff == S_CHECK, probe_ff <= DEP_W'(TABLE_DEPTH - 1))
endmodule

// ===== rtl/string_key_hash_table_core.sv =====
// Top level of the string key hash table: front part, command queue and back part.
//
// Channel  Direction  Handshake            Payload
// req      in         req_tvalid/tready    tdata {value, key_char}, tuser func, tlast last
// rsp      out        rsp_tvalid/tready    tdata {entry_count, value_res}, tuser status
//
// After reset the slot memory is cleared one slot per cycle, with req_tready held low.
// A non-zero character within the key length is accepted while its hash product is formed,
// and S_MOD then reduces the product modulo the depth by a reciprocal multiplication; other
// items need no reduction. A final item then queues its command in S_PUSH; the back part
// reads each slot it probes in S_READ and checks it in S_CHECK through the single memory
// read port. A stalled result holds the back part; the front part keeps filling the queue.
module string_key_hash_table_core #(
   parameter int TABLE_DEPTH = 1024,
   parameter int KEY_LEN     = 20
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [skht_pkg::REQ_DATA_W-1:0]      req_tdata,  // key_char[6:0], value[37:7]
   input  logic [0:0]                           req_tuser,  // func[0]
   input  logic                                 req_tlast,  // last character of the key
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [skht_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // value_res[30:0], entry_count[41:31]
   output logic [2:0]                           rsp_tuser   // status[2:0]
);
   import skht_pkg::*;

   localparam int KEY_W  = KEY_LEN * CHAR_W;
   localparam int HASH_W = $clog2(TABLE_DEPTH);
   localparam int CMD_W  = $bits(cmd_ctrl_type) + KEY_W + HASH_W + VALUE_W;
   localparam int PAD_W  = RSP_DATA_W - VALUE_W - COUNT_W;

   logic                 clearing;
   logic                 cmd_push, cmd_full, cmd_pop, cmd_empty;
   cmd_ctrl_type         front_ctrl, back_ctrl;
   logic [KEY_W-1:0]     front_key, back_key;
   logic [HASH_W-1:0]    front_home, back_home;
   logic [VALUE_W-1:0]   front_value, back_value;
   logic [CMD_W-1:0]     push_data, pop_data;
   status_type           rsp_status;
   logic [VALUE_W-1:0]   rsp_value_res;
   logic [COUNT_W-1:0]   rsp_entry_count;

   skht_front #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_LEN     (KEY_LEN)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .hold         (clearing),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_func     (req_tuser[0]),
      .req_key_char (req_tdata[CHAR_W-1:0]),
      .req_last     (req_tlast),
      .req_value    (req_tdata[CHAR_W +: VALUE_W]),
      .cmd_push     (cmd_push),
      .cmd_full     (cmd_full),
      .cmd_ctrl     (front_ctrl),
      .cmd_key      (front_key),
      .cmd_home     (front_home),
      .cmd_value    (front_value)
   );

   assign push_data = {front_ctrl, front_key, front_home, front_value};
   assign {back_ctrl, back_key, back_home, back_value} = pop_data;

   skht_cmd_fifo #(
      .WIDTH (CMD_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (push_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (pop_data),
      .empty     (cmd_empty)
   );

   skht_back #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_LEN     (KEY_LEN)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .clearing        (clearing),
      .cmd_empty       (cmd_empty),
      .cmd_pop         (cmd_pop),
      .cmd_ctrl        (back_ctrl),
      .cmd_key         (back_key),
      .cmd_home        (back_home),
      .cmd_value       (back_value),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_status      (rsp_status),
      .rsp_value_res   (rsp_value_res),
      .rsp_entry_count (rsp_entry_count)
   );

   assign rsp_tdata = {{PAD_W{1'b0}}, rsp_entry_count, rsp_value_res};
   assign rsp_tuser = rsp_status;
endmodule
